FILE: hdl/grc_pkg.sv
// Shared types and constants for the grid ray cast block.
// No dependencies; compiled first.
`default_nettype none

package grc_pkg;

   // Command codes carried by an input item
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_CAST = 1'b1;

   // Configuration register indexes
   localparam logic CSR_MAP_WIDTH  = 1'b0;
   localparam logic CSR_MAP_HEIGHT = 1'b1;

   // Field and register widths
   localparam int unsigned CELL_W   = 8;
   localparam int unsigned TARGET_W = 13;
   localparam int unsigned CSR_W    = 9;
   localparam int unsigned CSR_IDX_W = 1;

   // Walk sequencer
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_HOLD
   } state_type;

endpackage

`default_nettype wire

FILE: hdl/grc_if.sv
// Valid/ready channel interfaces for request and result items.
// Depends on grc_pkg for field widths.
`default_nettype none

interface grc_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  command;
   logic [grc_pkg::CELL_W-1:0]            cell_x;
   logic [grc_pkg::CELL_W-1:0]            cell_y;
   logic                                  cell_free;
   logic signed [grc_pkg::TARGET_W-1:0]   target_x;
   logic signed [grc_pkg::TARGET_W-1:0]   target_y;

   modport source (output valid, command, cell_x, cell_y, cell_free, target_x, target_y,
                   input ready);
   modport sink   (input valid, command, cell_x, cell_y, cell_free, target_x, target_y,
                   output ready);
endinterface

interface grc_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [grc_pkg::CELL_W-1:0] end_x;
   logic [grc_pkg::CELL_W-1:0] end_y;

   modport source (output valid, end_x, end_y, input ready);
   modport sink   (input valid, end_x, end_y, output ready);
endinterface

`default_nettype wire

FILE: hdl/grc_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module grc_ram #(
   parameter int unsigned WIDTH = 1,
   parameter int unsigned DEPTH = 65536
) (
   input  wire                        clock,
   input  wire                        wr_en,
   input  wire [$clog2(DEPTH)-1:0]    wr_addr,
   input  wire [WIDTH-1:0]            wr_data,
   input  wire                        rd_en,
   input  wire [$clog2(DEPTH)-1:0]    rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hdl/grid_ray_cast_to_obstacle.sv
// Grid ray cast top level: occupancy map RAM plus Bresenham walk sequencer.
// Depends on grc_pkg, grc_if and grc_ram.
`default_nettype none

// A load item writes one cell of the one-bit free map and gives no result. A
// cast item walks the Bresenham line from the start cell toward the target,
// one map cell per cycle through a shared step unit (error update,
// coordinate step), with the map read pipelined behind it and its data checked
// in the following cycle. The walk stops at the map edge, at a blocked cell or
// at the target and returns the last free cell, or the start cell if no cell
// was found free. Each cell is read on the RAM read port (a blocked cell is
// read too); the walk then sees the last read or the edge and hands the result
// to the output register. The next item is taken once the block is back in
// idle. The block takes no new item while a cast walks; it does take one while
// a finished result waits at the output, and a cast then holds its result
// until the output frees up. The map is not cleared: reading a never-loaded
// cell gives an arbitrary answer.

module grid_ray_cast_to_obstacle #(
   parameter int unsigned MAP_WIDTH  = 256,
   parameter int unsigned MAP_HEIGHT = 256
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              csr_we,
   input  wire [grc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire [grc_pkg::CSR_W-1:0]         csr_wdata,
   grc_req_if.sink                          req,
   grc_rsp_if.source                        rsp
);

   // Usable map: cells beyond 255 can be neither loaded nor reported
   localparam int unsigned COLS   = (MAP_WIDTH  < 256) ? MAP_WIDTH  : 256;
   localparam int unsigned ROWS   = (MAP_HEIGHT < 256) ? MAP_HEIGHT : 256;
   localparam int unsigned DEPTH  = COLS * ROWS;
   localparam int unsigned ADDR_W = $clog2(DEPTH);
   localparam int unsigned POS_W  = 10;   // signed walk coordinate, -1 .. 256
   localparam int unsigned DX_W   = 14;   // |target - start| up to 4351
   localparam int unsigned ERR_W  = 15;
   localparam int unsigned E2_W   = 16;
   localparam int unsigned CW     = grc_pkg::CELL_W;
   localparam int unsigned TW     = grc_pkg::TARGET_W;

   // Configuration registers
   logic [grc_pkg::CSR_W-1:0] map_width_ff;
   logic [grc_pkg::CSR_W-1:0] map_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= 9'd256;
         map_height_ff <= 9'd256;
      end else if (csr_we) begin
         unique case (csr_index)
            grc_pkg::CSR_MAP_WIDTH:  map_width_ff  <= csr_wdata;
            grc_pkg::CSR_MAP_HEIGHT: map_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Effective extent
   logic [grc_pkg::CSR_W-1:0] ext_w;
   logic [grc_pkg::CSR_W-1:0] ext_h;

   assign ext_w = (map_width_ff  > 9'(COLS)) ? 9'(COLS) : map_width_ff;
   assign ext_h = (map_height_ff > 9'(ROWS)) ? 9'(ROWS) : map_height_ff;

   // Sequencer and walk registers
   grc_pkg::state_type state_ff, state_in;

   logic signed [POS_W-1:0] cur_x_ff, cur_x_in;
   logic signed [POS_W-1:0] cur_y_ff, cur_y_in;
   logic signed [ERR_W-1:0] err_ff, err_in;
   logic signed [DX_W-1:0]  dx_ff, dx_in;
   logic signed [DX_W-1:0]  dy_ff, dy_in;
   logic                    sx_ff, sx_in;
   logic                    sy_ff, sy_in;
   logic signed [TW-1:0]    tgt_x_ff, tgt_x_in;
   logic signed [TW-1:0]    tgt_y_ff, tgt_y_in;
   logic [CW-1:0]           last_x_ff, last_x_in;
   logic [CW-1:0]           last_y_ff, last_y_in;
   logic                    pend_valid_ff, pend_valid_in;
   logic [CW-1:0]           pend_x_ff, pend_x_in;
   logic [CW-1:0]           pend_y_ff, pend_y_in;
   logic                    pend_tgt_ff, pend_tgt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]           end_x_ff, end_x_in;
   logic [CW-1:0]           end_y_ff, end_y_in;

   // Map RAM ports
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic              ram_re;
   logic [ADDR_W-1:0] ram_raddr;
   logic              ram_rdata;

   grc_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req.cell_free),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   logic req_fire;
   logic slot_free;

   assign req.ready = (state_ff == grc_pkg::ST_IDLE);
   assign req_fire  = req.valid && req.ready;
   assign slot_free = !rsp_valid_ff || rsp.ready;

   // Load items: writes outside the parameter size are dropped
   assign ram_we    = req_fire && (req.command == grc_pkg::CMD_LOAD)
                      && ({1'b0, req.cell_x} < 9'(COLS)) && ({1'b0, req.cell_y} < 9'(ROWS));
   assign ram_waddr = ADDR_W'(32'(req.cell_y) * COLS + 32'(req.cell_x));
   assign ram_raddr = ADDR_W'(32'(cur_y_ff[CW-1:0]) * COLS + 32'(cur_x_ff[CW-1:0]));

   // Setup of a cast: deltas and directions
   logic signed [TW:0] start_x_ext;
   logic signed [TW:0] start_y_ext;
   logic signed [TW:0] diff_x;
   logic signed [TW:0] diff_y;

   assign start_x_ext = $signed({6'd0, req.cell_x});
   assign start_y_ext = $signed({6'd0, req.cell_y});
   assign diff_x      = (TW+1)'(req.target_x) - start_x_ext;
   assign diff_y      = (TW+1)'(req.target_y) - start_y_ext;

   // Shared step unit: one Bresenham step per cycle
   logic signed [E2_W-1:0] e2;
   logic                   step_x;
   logic                   step_y;
   logic signed [ERR_W-1:0] err_step;
   logic                   cur_oob;
   logic                   cur_is_tgt;

   assign e2       = {E2_W'(err_ff)} <<< 1;
   assign step_x   = e2 >= E2_W'(dy_ff);
   assign step_y   = e2 <= E2_W'(dx_ff);
   assign err_step = err_ff + (step_x ? ERR_W'(dy_ff) : ERR_W'(0))
                            + (step_y ? ERR_W'(dx_ff) : ERR_W'(0));
   assign cur_oob  = cur_x_ff[POS_W-1] || cur_y_ff[POS_W-1]
                     || (cur_x_ff[8:0] >= ext_w) || (cur_y_ff[8:0] >= ext_h);
   assign cur_is_tgt = (TW'(cur_x_ff) == tgt_x_ff) && (TW'(cur_y_ff) == tgt_y_ff);

   // Next state and datapath
   always_comb begin
      logic done;

      state_in      = state_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      err_in        = err_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      sx_in         = sx_ff;
      sy_in         = sy_ff;
      tgt_x_in      = tgt_x_ff;
      tgt_y_in      = tgt_y_ff;
      last_x_in     = last_x_ff;
      last_y_in     = last_y_ff;
      pend_valid_in = 1'b0;
      pend_x_in     = pend_x_ff;
      pend_y_in     = pend_y_ff;
      pend_tgt_in   = pend_tgt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      end_x_in      = end_x_ff;
      end_y_in      = end_y_ff;
      ram_re        = 1'b0;
      done          = 1'b0;

      unique case (state_ff)
         grc_pkg::ST_IDLE: begin
            if (req_fire && (req.command == grc_pkg::CMD_CAST)) begin
               dx_in     = DX_W'(diff_x[TW] ? -diff_x : diff_x);
               dy_in     = DX_W'(diff_y[TW] ? diff_y : -diff_y);
               sx_in     = !diff_x[TW] && (diff_x != '0);
               sy_in     = !diff_y[TW] && (diff_y != '0);
               err_in    = ERR_W'(DX_W'(diff_x[TW] ? -diff_x : diff_x))
                           + ERR_W'(DX_W'(diff_y[TW] ? diff_y : -diff_y));
               tgt_x_in  = req.target_x;
               tgt_y_in  = req.target_y;
               cur_x_in  = $signed({2'b00, req.cell_x});
               cur_y_in  = $signed({2'b00, req.cell_y});
               last_x_in = req.cell_x;
               last_y_in = req.cell_y;
               state_in  = grc_pkg::ST_WALK;
            end
         end
         grc_pkg::ST_WALK: begin
            // Cell read last cycle comes back first
            if (pend_valid_ff) begin
               if (!ram_rdata) begin
                  done = 1'b1;
               end else begin
                  last_x_in = pend_x_ff;
                  last_y_in = pend_y_ff;
                  if (pend_tgt_ff) begin
                     done = 1'b1;
                  end
               end
            end
            if (!done && cur_oob) begin
               done = 1'b1;
            end
            if (done) begin
               state_in = grc_pkg::ST_HOLD;
            end else begin
               // Issue the current cell and step along the line
               ram_re        = 1'b1;
               pend_valid_in = 1'b1;
               pend_x_in     = cur_x_ff[CW-1:0];
               pend_y_in     = cur_y_ff[CW-1:0];
               pend_tgt_in   = cur_is_tgt;
               err_in        = err_step;
               if (step_x) begin
                  cur_x_in = sx_ff ? cur_x_ff + POS_W'(1) : cur_x_ff - POS_W'(1);
               end
               if (step_y) begin
                  cur_y_in = sy_ff ? cur_y_ff + POS_W'(1) : cur_y_ff - POS_W'(1);
               end
            end
         end
         grc_pkg::ST_HOLD: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               end_x_in     = last_x_ff;
               end_y_in     = last_y_ff;
               state_in     = grc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = grc_pkg::ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= grc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      err_ff      <= err_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      tgt_x_ff    <= tgt_x_in;
      tgt_y_ff    <= tgt_y_in;
      last_x_ff   <= last_x_in;
      last_y_ff   <= last_y_in;
      pend_x_ff   <= pend_x_in;
      pend_y_ff   <= pend_y_in;
      pend_tgt_ff <= pend_tgt_in;
      end_x_ff    <= end_x_in;
      end_y_ff    <= end_y_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.end_x = end_x_ff;
   assign rsp.end_y = end_y_ff;

   // Checks
   logic signed [POS_W-1:0] gap_x;
   logic signed [POS_W-1:0] gap_y;

   assign gap_x = cur_x_ff - $signed({2'b00, pend_x_ff});
   assign gap_y = cur_y_ff - $signed({2'b00, pend_y_ff});

   // A cell in flight was inside the map when it was issued
   a_pend_in_map: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> ({1'b0, pend_x_ff} < ext_w) && ({1'b0, pend_y_ff} < ext_h))
      else $error("cell in flight lies outside the map");

   // The walk position is one step past the cell in flight
   a_step_adjacent: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (gap_x == -1 || gap_x == 0 || gap_x == 1)
                     && (gap_y == -1 || gap_y == 0 || gap_y == 1))
      else $error("walk moved more than one cell per step");

   // A read is only in flight during a walk
   a_pend_in_walk: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (state_ff == grc_pkg::ST_WALK))
      else $error("map read in flight outside a walk");

   // A result appears only after a finished walk
   a_rsp_from_hold: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == grc_pkg::ST_HOLD))
      else $error("result produced without a finished walk");

endmodule

`default_nettype wire

FILE: tb/tb_grid_ray_cast_to_obstacle.sv
`timescale 1ns / 1ps
// Self-checking bench for grid_ray_cast_to_obstacle: map loads and ray casts
// checked against an in-bench Bresenham walk. Needs grc_pkg, grc_if and the RTL.

module tb_grid_ray_cast_to_obstacle;

   localparam int MAP_COLS = 256;
   localparam int MAP_ROWS = 256;

   typedef struct {
      logic                                command;
      logic [grc_pkg::CELL_W-1:0]          cell_x;
      logic [grc_pkg::CELL_W-1:0]          cell_y;
      logic                                cell_free;
      logic signed [grc_pkg::TARGET_W-1:0] target_x;
      logic signed [grc_pkg::TARGET_W-1:0] target_y;
   } ray_req_type;

   typedef struct {
      logic [grc_pkg::CELL_W-1:0] x;
      logic [grc_pkg::CELL_W-1:0] y;
   } map_cell_type;

   // Mirror of the occupancy map plus the queue of ray end cells still owed
   class ray_end_scoreboard_type;
      bit           free_bit [MAP_ROWS][MAP_COLS];
      bit           loaded   [MAP_ROWS][MAP_COLS];
      int           cols;
      int           rows;
      map_cell_type expected_ends [$];
      int           mismatches;

      function new();
         cols = MAP_COLS;
         rows = MAP_ROWS;
         mismatches = 0;
      endfunction

      function int pending();
         return expected_ends.size();
      endfunction

      // Usable extent is the register clamped to the map size
      function void set_extent(logic [grc_pkg::CSR_IDX_W-1:0] idx, int unsigned val);
         int unsigned lim;
         lim = (idx == grc_pkg::CSR_MAP_WIDTH) ? MAP_COLS : MAP_ROWS;
         if (val > lim) val = lim;
         if (idx == grc_pkg::CSR_MAP_WIDTH) cols = int'(val);
         else rows = int'(val);
      endfunction

      // Walk the line; stops early on a cell never loaded and reports it
      function void trace(input ray_req_type r, output map_cell_type stop,
                          output bit unknown, output map_cell_type hole);
         int x0, y0, x1, y1, dx, dy, sx, sy, err, e2, x, y, lx, ly;
         bit done;
         x0 = int'(r.cell_x);
         y0 = int'(r.cell_y);
         x1 = int'(r.target_x);
         y1 = int'(r.target_y);
         dx = (x1 > x0) ? x1 - x0 : x0 - x1;
         dy = (y1 > y0) ? y0 - y1 : y1 - y0;
         sx = (x0 < x1) ? 1 : -1;
         sy = (y0 < y1) ? 1 : -1;
         err = dx + dy;
         x = x0;
         y = y0;
         lx = x0;
         ly = y0;
         unknown = 1'b0;
         hole.x = '0;
         hole.y = '0;
         done = 1'b0;
         while (!done) begin
            if (x < 0 || x >= cols || y < 0 || y >= rows) begin
               done = 1'b1;
            end else if (!loaded[y][x]) begin
               unknown = 1'b1;
               hole.x = x[grc_pkg::CELL_W-1:0];
               hole.y = y[grc_pkg::CELL_W-1:0];
               done = 1'b1;
            end else if (!free_bit[y][x]) begin
               done = 1'b1;
            end else begin
               lx = x;
               ly = y;
               if (x == x1 && y == y1) begin
                  done = 1'b1;
               end else begin
                  e2 = 2 * err;
                  if (e2 >= dy) begin
                     err += dy;
                     x += sx;
                  end
                  if (e2 <= dx) begin
                     err += dx;
                     y += sy;
                  end
               end
            end
         end
         stop.x = lx[grc_pkg::CELL_W-1:0];
         stop.y = ly[grc_pkg::CELL_W-1:0];
      endfunction

      function void note_item(ray_req_type r);
         map_cell_type stop, hole;
         bit           unknown;
         if (r.command == grc_pkg::CMD_LOAD) begin
            // any 8-bit cell lies inside a 256 x 256 map
            free_bit[r.cell_y][r.cell_x] = r.cell_free;
            loaded[r.cell_y][r.cell_x] = 1'b1;
         end else begin
            trace(r, stop, unknown, hole);
            if (unknown) begin
               $error("cast reads unloaded cell (%0d,%0d)", hole.x, hole.y);
               mismatches++;
            end
            expected_ends = {expected_ends, stop};
         end
      endfunction

      function void check_result(logic [grc_pkg::CELL_W-1:0] got_x,
                                 logic [grc_pkg::CELL_W-1:0] got_y);
         map_cell_type want;
         if (expected_ends.size() == 0) begin
            $error("result (%0d,%0d) with no cast outstanding", got_x, got_y);
            mismatches++;
         end else begin
            want = expected_ends.pop_front();
            if (got_x !== want.x) begin
               $error("end_x: expected %0d, got %0d", want.x, got_x);
               mismatches++;
            end
            if (got_y !== want.y) begin
               $error("end_y: expected %0d, got %0d", want.y, got_y);
               mismatches++;
            end
         end
      endfunction
   endclass

   logic                          clock;
   logic                          reset;
   logic                          csr_we;
   logic [grc_pkg::CSR_IDX_W-1:0] csr_index;
   logic [grc_pkg::CSR_W-1:0]     csr_wdata;

   grc_req_if req_ch ();
   grc_rsp_if rsp_ch ();

   ray_end_scoreboard_type sb = new();

   int items_sent = 0;
   bit calm = 1'b0;          // no idling on either side
   bit hold_results = 1'b0;  // asks the result side for one long stall

   grid_ray_cast_to_obstacle dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req       (req_ch),
      .rsp       (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #30_000_000;
      $display("tb: failure");
      $finish;
   end

   // Result side: random ready bursts, one long hold-off on request
   initial begin
      forever begin
         if (hold_results) begin
            hold_results = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (400) @(posedge clock);
         end else if (calm || $urandom_range(0, 3) != 0) begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_result(rsp_ch.end_x, rsp_ch.end_y);
   end

   // Offer one item, wait for it to be taken, maybe leave a gap after it
   task automatic send_item(input ray_req_type r);
      req_ch.valid     <= 1'b1;
      req_ch.command   <= r.command;
      req_ch.cell_x    <= r.cell_x;
      req_ch.cell_y    <= r.cell_y;
      req_ch.cell_free <= r.cell_free;
      req_ch.target_x  <= r.target_x;
      req_ch.target_y  <= r.target_y;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
      sb.note_item(r);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   task automatic send_load(input int x, input int y, input bit is_free);
      ray_req_type r;
      int unsigned rnd;
      rnd = $urandom;
      r.command   = grc_pkg::CMD_LOAD;
      r.cell_x    = x[grc_pkg::CELL_W-1:0];
      r.cell_y    = y[grc_pkg::CELL_W-1:0];
      r.cell_free = is_free;
      r.target_x  = rnd[grc_pkg::TARGET_W-1:0];
      r.target_y  = rnd[grc_pkg::TARGET_W+15:16];
      send_item(r);
   endtask

   // Load every cell the ray would reach first, then cast it
   task automatic cast_ray(input int x0, input int y0, input int tx, input int ty,
                           input int blocked_pct);
      ray_req_type  r;
      map_cell_type stop, hole;
      bit           unknown;
      int unsigned  rnd;
      rnd = $urandom;
      r.command   = grc_pkg::CMD_CAST;
      r.cell_x    = x0[grc_pkg::CELL_W-1:0];
      r.cell_y    = y0[grc_pkg::CELL_W-1:0];
      r.cell_free = rnd[0];
      r.target_x  = tx[grc_pkg::TARGET_W-1:0];
      r.target_y  = ty[grc_pkg::TARGET_W-1:0];
      sb.trace(r, stop, unknown, hole);
      while (unknown) begin
         send_load(int'(hole.x), int'(hole.y), $urandom_range(0, 99) >= blocked_pct);
         sb.trace(r, stop, unknown, hole);
      end
      send_item(r);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic [grc_pkg::CSR_IDX_W-1:0] idx,
                            input int unsigned val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[grc_pkg::CSR_W-1:0];
      @(posedge clock);
      sb.set_extent(idx, 32'(val[grc_pkg::CSR_W-1:0]));
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Corners, off-map targets, blocked start, axis and diagonal rays, 1 x 1 map
   task automatic directed_part();
      write_csr(grc_pkg::CSR_MAP_WIDTH, 256);
      write_csr(grc_pkg::CSR_MAP_HEIGHT, 256);
      send_load(0, 0, 1'b1);
      send_load(255, 255, 1'b1);
      send_load(255, 0, 1'b1);
      send_load(0, 255, 1'b1);
      cast_ray(0, 0, 0, 0, 0);
      cast_ray(255, 255, 4095, 4095, 0);
      cast_ray(0, 255, -4096, -4096, 0);
      cast_ray(255, 0, 4095, -4096, 0);
      send_load(10, 10, 1'b0);
      cast_ray(10, 10, 50, 20, 0);
      cast_ray(100, 100, 100, 110, 0);
      cast_ray(100, 100, 92, 100, 0);
      cast_ray(128, 128, 134, 122, 0);
      cast_ray(5, 5, 17, 8, 30);
      send_load(255, 255, 1'b0);
      cast_ray(250, 250, 255, 255, 0);
      drain();
      write_csr(grc_pkg::CSR_MAP_WIDTH, 1);
      write_csr(grc_pkg::CSR_MAP_HEIGHT, 1);
      cast_ray(0, 0, 3, 3, 0);
      cast_ray(200, 200, 0, 0, 0);
      cast_ray(0, 0, -1, 0, 0);
   endtask

   task automatic run_phase(input int width_reg, input int height_reg, input int n_items,
                            input bit squeeze);
      int  blocked_pct, first, reach, x0, y0, tx, ty;
      bit  held, paused;
      drain();
      write_csr(grc_pkg::CSR_MAP_WIDTH, width_reg);
      write_csr(grc_pkg::CSR_MAP_HEIGHT, height_reg);
      blocked_pct = $urandom_range(5, 35);
      first = items_sent;
      held = 1'b0;
      paused = 1'b0;
      while (items_sent - first < n_items) begin
         if (squeeze && !held && items_sent - first >= 20) begin
            held = 1'b1;
            hold_results = 1'b1;
         end
         if (!paused && items_sent - first >= n_items / 2) begin
            paused = 1'b1;
            drain();
         end
         if ($urandom_range(0, 99) < 15) begin
            send_load($urandom_range(0, 255), $urandom_range(0, 255),
                      1'($urandom_range(0, 1)));
         end else begin
            // mostly start on the map, sometimes anywhere
            if ($urandom_range(0, 99) < 85) begin
               x0 = $urandom_range(0, width_reg - 1);
               y0 = $urandom_range(0, height_reg - 1);
            end else begin
               x0 = $urandom_range(0, 255);
               y0 = $urandom_range(0, 255);
            end
            case ($urandom_range(0, 9))
               0, 1, 2, 3: begin
                  reach = $urandom_range(0, 24);
                  tx = x0 + int'($urandom_range(0, 2 * reach)) - reach;
                  ty = y0 + int'($urandom_range(0, 2 * reach)) - reach;
               end
               4, 5: begin
                  tx = $urandom_range(0, width_reg - 1);
                  ty = $urandom_range(0, height_reg - 1);
               end
               6, 7: begin
                  tx = int'($urandom_range(0, 8191)) - 4096;
                  ty = int'($urandom_range(0, 8191)) - 4096;
               end
               8: begin
                  tx = $urandom_range(0, 1) ? 4095 : -4096;
                  ty = $urandom_range(0, 1) ? 4095 : -4096;
               end
               default: begin
                  // straight along one axis
                  if ($urandom_range(0, 1)) begin
                     tx = x0;
                     ty = int'($urandom_range(0, 8191)) - 4096;
                  end else begin
                     tx = int'($urandom_range(0, 8191)) - 4096;
                     ty = y0;
                  end
               end
            endcase
            cast_ray(x0, y0, tx, ty, blocked_pct);
         end
      end
   endtask

   initial begin
      reset            <= 1'b1;
      csr_we           <= 1'b0;
      csr_index        <= grc_pkg::CSR_MAP_WIDTH;
      csr_wdata        <= '0;
      req_ch.valid     <= 1'b0;
      req_ch.command   <= grc_pkg::CMD_LOAD;
      req_ch.cell_x    <= '0;
      req_ch.cell_y    <= '0;
      req_ch.cell_free <= 1'b0;
      req_ch.target_x  <= '0;
      req_ch.target_y  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      directed_part();
      run_phase(256, 256, 140, 1'b1);
      run_phase(1, 256, 100, 1'b0);
      run_phase(256, 1, 100, 1'b0);
      run_phase(16, 16, 120, 1'b0);
      run_phase($urandom_range(2, 255), $urandom_range(2, 255), 140, 1'b1);
      run_phase(256, 256, 120, 1'b0);
      calm = 1'b1;
      run_phase($urandom_range(1, 256), $urandom_range(1, 256), 80, 1'b0);

      drain();
      repeat (16) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
